/* hw/rtl/cache_line_request_splitter_top_defines.svh */
// assertion macros for the cache line request splitter
`ifndef CACHE_LINE_REQUEST_SPLITTER_TOP_DEFINES_SVH
`define CACHE_LINE_REQUEST_SPLITTER_TOP_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define CLRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define CLRS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/clrs_pkg.sv */
// shared types and constants of the cache line request splitter
package clrs_pkg;

  localparam int ADDR_W     = 64;
  localparam int BYTES_W    = 13;
  localparam int KIND_W     = 3;
  localparam int OP_KINDS   = 8;
  localparam int CNT_W      = 7;
  localparam int LG_W       = 4;
  localparam int LINE_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 3;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_QUEUE_DEPTH  = 2;

  localparam logic [LG_W-1:0]  RST_LINE_LOG2 = 4'd6;
  localparam logic [CNT_W-1:0] RST_LIMIT     = 7'd64;

  typedef enum logic [STATUS_W-1:0] {
    ST_SEGMENT     = 3'd0,
    ST_RETRY       = 3'd1,
    ST_NEVER       = 3'd2,
    ST_ATOMIC_SPAN = 3'd3,
    ST_DONE_OK     = 3'd4,
    ST_UNDERFLOW   = 3'd5
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ        = 3'd0,
    KIND_WRITE       = 3'd1,
    KIND_FLUSH       = 3'd2,
    KIND_READLOCK    = 3'd3,
    KIND_WRITEUNLOCK = 3'd4,
    KIND_LOADLINK    = 3'd5,
    KIND_STORECOND   = 3'd6,
    KIND_CUSTOM      = 3'd7
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CACHE_PRESENT   = 3'd0,
    CFG_LINE_LOG2       = 3'd1,
    CFG_LIMIT_READ      = 3'd2,
    CFG_LIMIT_WRITE     = 3'd3,
    CFG_LIMIT_FLUSH     = 3'd4,
    CFG_LIMIT_LOCK_PAIR = 3'd5,
    CFG_LIMIT_LINK_PAIR = 3'd6,
    CFG_LIMIT_CUSTOM    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             cache_present;
    logic [LG_W-1:0]  line_log2;
    logic [CNT_W-1:0] limit_read;
    logic [CNT_W-1:0] limit_write;
    logic [CNT_W-1:0] limit_flush;
    logic [CNT_W-1:0] limit_lock_pair;
    logic [CNT_W-1:0] limit_link_pair;
    logic [CNT_W-1:0] limit_custom;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
    logic [BYTES_W-1:0] rest;
    logic [LG_W-1:0]    lg;
  } job_t;

endpackage

/* hw/rtl/clrs_front.sv */
// front end: request intake, segment count, credit check and outstanding counters
module clrs_front #(
  parameter int MAX_SEGMENTS = clrs_pkg::DEF_MAX_SEGMENTS,
  parameter int SEG_W        = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  clrs_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [clrs_pkg::KIND_W-1:0]  in_op_kind,
  input  logic [clrs_pkg::ADDR_W-1:0]  in_address,
  input  logic [clrs_pkg::BYTES_W-1:0] in_byte_count,
  input  logic                         in_cacheable,
  input  logic                         in_atomic,
  input  logic                         q_full,
  output logic                         push,
  output clrs_pkg::job_t               push_entry,
  output logic [SEG_W-1:0]             push_segs
);

  localparam int LW = clrs_pkg::LINE_W;
  localparam int BW = clrs_pkg::BYTES_W;
  localparam int CW = clrs_pkg::CNT_W;

  logic                        s_v_r, s_v_nxt;
  logic                        s_req_r;
  logic [clrs_pkg::KIND_W-1:0] s_kind_r;
  logic [clrs_pkg::ADDR_W-1:0] s_addr_r;
  logic [BW-1:0]               s_left_r;
  logic                        s_cached_r;
  logic                        s_atomic_r;
  logic [LW-1:0]               s_lines_r;
  logic [BW-1:0]               s_first_r;
  logic [CW-1:0]               cnt_r [clrs_pkg::OP_KINDS];

  logic          accept;
  logic          cached;
  logic [LW-1:0] line;
  logic [LW-1:0] off;
  logic [LW:0]   span;
  logic [LW-1:0] lines_calc;
  logic [LW-1:0] room;
  logic [BW-1:0] first_calc;

  logic [CW-1:0] cur;
  logic [CW-1:0] lim;
  logic [CW:0]   credit_sum;
  logic          cnt_we;
  logic [CW-1:0] cnt_new;

  assign in_stall = s_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = s_v_r && !q_full;

  // segment count and first segment size of the incoming request
  always_comb begin
    cached     = cfg.cache_present && in_cacheable;
    line       = LW'(1) << cfg.line_log2;
    off        = in_address[LW-1:0] & (line - LW'(1));
    span       = {1'b0, off} + (LW+1)'(in_byte_count) - (LW+1)'(1);
    lines_calc = LW'((span >> cfg.line_log2) + (LW+1)'(1));
    if (!cached || in_byte_count == '0) begin
      lines_calc = LW'(1);
    end
    room       = line - off;
    first_calc = (room > LW'(in_byte_count)) ? in_byte_count : room[BW-1:0];
  end

  always_comb begin
    s_v_nxt = s_v_r;
    if (accept) begin
      s_v_nxt = 1'b1;
    end else if (push) begin
      s_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= s_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_req_r    <= in_req_type;
      s_kind_r   <= in_op_kind;
      s_addr_r   <= in_address;
      s_left_r   <= in_byte_count;
      s_cached_r <= cached;
      s_atomic_r <= in_atomic;
      s_lines_r  <= lines_calc;
      s_first_r  <= first_calc;
    end
  end

  always_comb begin
    unique case (clrs_pkg::kind_t'(s_kind_r))
      clrs_pkg::KIND_READ:        lim = cfg.limit_read;
      clrs_pkg::KIND_WRITE:       lim = cfg.limit_write;
      clrs_pkg::KIND_FLUSH:       lim = cfg.limit_flush;
      clrs_pkg::KIND_READLOCK,
      clrs_pkg::KIND_WRITEUNLOCK: lim = cfg.limit_lock_pair;
      clrs_pkg::KIND_LOADLINK,
      clrs_pkg::KIND_STORECOND:   lim = cfg.limit_link_pair;
      clrs_pkg::KIND_CUSTOM:      lim = cfg.limit_custom;
      default:                    lim = cfg.limit_custom;
    endcase
  end

  // check cycle
  always_comb begin
    cur              = cnt_r[s_kind_r];
    credit_sum       = {1'b0, cur} + {1'b0, s_lines_r[CW-1:0]};
    cnt_we           = 1'b0;
    cnt_new          = cur;
    push_entry.kind  = s_kind_r;
    push_entry.lg    = cfg.line_log2;
    push_entry.addr  = '0;
    push_entry.bytes = '0;
    push_entry.rest  = '0;
    push_segs        = SEG_W'(1);
    priority if (s_req_r) begin
      if (cur == '0) begin
        push_entry.status = clrs_pkg::ST_UNDERFLOW;
      end else begin
        push_entry.status = clrs_pkg::ST_DONE_OK;
        cnt_we            = 1'b1;
        cnt_new           = cur - CW'(1);
      end
    end else if (s_lines_r > LW'(1) && s_atomic_r) begin
      push_entry.status = clrs_pkg::ST_ATOMIC_SPAN;
    end else if (s_lines_r > LW'(lim) || s_lines_r > LW'(MAX_SEGMENTS)) begin
      push_entry.status = clrs_pkg::ST_NEVER;
    end else if (credit_sum > (CW+1)'(lim)) begin
      push_entry.status = clrs_pkg::ST_RETRY;
    end else begin
      push_entry.status = clrs_pkg::ST_SEGMENT;
      cnt_we            = 1'b1;
      cnt_new           = credit_sum[CW-1:0];
      push_entry.addr   = s_addr_r;
      push_segs         = s_lines_r[SEG_W-1:0];
      if (s_cached_r) begin
        push_entry.bytes = s_first_r;
        push_entry.rest  = s_left_r - s_first_r;
      end else begin
        push_entry.bytes = s_left_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < clrs_pkg::OP_KINDS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (push && cnt_we) begin
      cnt_r[s_kind_r] <= cnt_new;
    end
  end

endmodule

/* hw/rtl/clrs_queue.sv */
// short queue of classified requests between front and back end
module clrs_queue #(
  parameter int DEPTH = clrs_pkg::DEF_QUEUE_DEPTH,
  parameter int SEG_W = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  clrs_pkg::job_t     push_entry,
  input  logic [SEG_W-1:0]   push_segs,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output clrs_pkg::job_t     head_entry,
  output logic [SEG_W-1:0]   head_segs
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  clrs_pkg::job_t   entry_r [DEPTH];
  logic [SEG_W-1:0] segs_r  [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full       = fill_r == FILL_W'(DEPTH);
  assign head_valid = fill_r != '0;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;
  assign head_entry = entry_r[rd_ptr_r];
  assign head_segs  = segs_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
      segs_r[wr_ptr_r]  <= push_segs;
    end
  end

endmodule

/* hw/rtl/clrs_back.sv */
// back end: walks a classified request line by line into the result register
module clrs_back #(
  parameter int SEG_W = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  clrs_pkg::job_t                 head_entry,
  input  logic [SEG_W-1:0]               head_segs,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [clrs_pkg::STATUS_W-1:0]  out_status,
  output logic [clrs_pkg::ADDR_W-1:0]    out_seg_address,
  output logic [clrs_pkg::BYTES_W-1:0]   out_seg_bytes,
  output logic [clrs_pkg::KIND_W-1:0]    out_seg_kind,
  output logic                           out_last
);

  localparam int LW = clrs_pkg::LINE_W;
  localparam int BW = clrs_pkg::BYTES_W;

  logic             job_v_r, job_v_nxt;
  clrs_pkg::job_t   job_r;
  logic [SEG_W-1:0] remain_r;

  logic             out_v_r, out_v_nxt;
  clrs_pkg::status_t out_status_r;
  logic [clrs_pkg::ADDR_W-1:0] out_addr_r;
  logic [BW-1:0]    out_bytes_r;
  logic [clrs_pkg::KIND_W-1:0] out_kind_r;
  logic             out_last_r;

  logic             emit;
  logic             seg_last;
  logic             last_emit;
  logic [LW-1:0]    line;
  logic [BW-1:0]    next_bytes;

  assign emit      = job_v_r && (!out_v_r || !out_stall);
  assign seg_last  = remain_r == SEG_W'(1);
  assign last_emit = emit && seg_last;
  assign pop       = head_valid && (!job_v_r || last_emit);

  assign line       = LW'(1) << job_r.lg;
  assign next_bytes = (LW'(job_r.rest) < line) ? job_r.rest : line[BW-1:0];

  always_comb begin
    job_v_nxt = job_v_r;
    if (pop) begin
      job_v_nxt = 1'b1;
    end else if (last_emit) begin
      job_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r    <= head_entry;
      remain_r <= head_segs;
    end else if (emit) begin
      job_r.addr  <= job_r.addr + clrs_pkg::ADDR_W'(job_r.bytes);
      job_r.bytes <= next_bytes;
      job_r.rest  <= job_r.rest - next_bytes;
      remain_r    <= remain_r - SEG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= job_r.status;
      out_addr_r   <= job_r.addr;
      out_bytes_r  <= job_r.bytes;
      out_kind_r   <= job_r.kind;
      out_last_r   <= seg_last;
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = out_status_r;
  assign out_seg_address = out_addr_r;
  assign out_seg_bytes   = out_bytes_r;
  assign out_seg_kind    = out_kind_r;
  assign out_last        = out_last_r;

endmodule

/* hw/rtl/cache_line_request_splitter_top.sv */
// top level of the cache line request splitter
// A request is either the issue of a memory access or the completion of one
// segment. An issue is checked against its kind's outstanding credit and,
// when a cache is present and the access is cacheable, cut at line
// boundaries; a completion returns one credit. The result of an accepted
// request passes through the check stage, which updates the credit counters
// and writes the queue, then the back end's job register and then the result
// register. While the output is not stalled, the back end gives one segment
// per cycle, so single-segment requests and completions stream at one per
// cycle; the front end stalls only when the queue between the two is full.
module cache_line_request_splitter_top #(
  parameter int MAX_SEGMENTS = clrs_pkg::DEF_MAX_SEGMENTS,
  parameter int QUEUE_DEPTH  = clrs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [clrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clrs_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [clrs_pkg::KIND_W-1:0]     in_op_kind,
  input  logic [clrs_pkg::ADDR_W-1:0]     in_address,
  input  logic [clrs_pkg::BYTES_W-1:0]    in_byte_count,
  input  logic                            in_cacheable,
  input  logic                            in_atomic,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [clrs_pkg::STATUS_W-1:0]   out_status,
  output logic [clrs_pkg::ADDR_W-1:0]     out_seg_address,
  output logic [clrs_pkg::BYTES_W-1:0]    out_seg_bytes,
  output logic [clrs_pkg::KIND_W-1:0]     out_seg_kind,
  output logic                            out_last
);

  localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int CW    = clrs_pkg::CNT_W;

  clrs_pkg::cfg_t   cfg_r, cfg_nxt;

  logic             q_full;
  logic             push;
  clrs_pkg::job_t   push_entry;
  logic [SEG_W-1:0] push_segs;
  logic             pop;
  logic             head_valid;
  clrs_pkg::job_t   head_entry;
  logic [SEG_W-1:0] head_segs;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (clrs_pkg::cfg_idx_t'(cfg_index))
        clrs_pkg::CFG_CACHE_PRESENT:   cfg_nxt.cache_present   = cfg_wdata[0];
        clrs_pkg::CFG_LINE_LOG2:       cfg_nxt.line_log2       = cfg_wdata[clrs_pkg::LG_W-1:0];
        clrs_pkg::CFG_LIMIT_READ:      cfg_nxt.limit_read      = cfg_wdata[CW-1:0];
        clrs_pkg::CFG_LIMIT_WRITE:     cfg_nxt.limit_write     = cfg_wdata[CW-1:0];
        clrs_pkg::CFG_LIMIT_FLUSH:     cfg_nxt.limit_flush     = cfg_wdata[CW-1:0];
        clrs_pkg::CFG_LIMIT_LOCK_PAIR: cfg_nxt.limit_lock_pair = cfg_wdata[CW-1:0];
        clrs_pkg::CFG_LIMIT_LINK_PAIR: cfg_nxt.limit_link_pair = cfg_wdata[CW-1:0];
        clrs_pkg::CFG_LIMIT_CUSTOM:    cfg_nxt.limit_custom    = cfg_wdata[CW-1:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cache_present   <= 1'b0;
      cfg_r.line_log2       <= clrs_pkg::RST_LINE_LOG2;
      cfg_r.limit_read      <= clrs_pkg::RST_LIMIT;
      cfg_r.limit_write     <= clrs_pkg::RST_LIMIT;
      cfg_r.limit_flush     <= clrs_pkg::RST_LIMIT;
      cfg_r.limit_lock_pair <= clrs_pkg::RST_LIMIT;
      cfg_r.limit_link_pair <= clrs_pkg::RST_LIMIT;
      cfg_r.limit_custom    <= clrs_pkg::RST_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  clrs_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SEG_W        (SEG_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_op_kind    (in_op_kind),
    .in_address    (in_address),
    .in_byte_count (in_byte_count),
    .in_cacheable  (in_cacheable),
    .in_atomic     (in_atomic),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry),
    .push_segs     (push_segs)
  );

  clrs_queue #(
    .DEPTH (QUEUE_DEPTH),
    .SEG_W (SEG_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_segs  (push_segs),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .head_segs  (head_segs)
  );

  clrs_back #(
    .SEG_W (SEG_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_entry      (head_entry),
    .head_segs       (head_segs),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_seg_address (out_seg_address),
    .out_seg_bytes   (out_seg_bytes),
    .out_seg_kind    (out_seg_kind),
    .out_last        (out_last)
  );

endmodule

/* hw/rtl/clrs_checker.sv */
// port-level checks of the cache line request splitter and their bind
`include "cache_line_request_splitter_top_defines.svh"

module clrs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [clrs_pkg::STATUS_W-1:0]  out_status,
  input logic [clrs_pkg::ADDR_W-1:0]    out_seg_address,
  input logic [clrs_pkg::BYTES_W-1:0]   out_seg_bytes,
  input logic                           out_last
);

  `CLRS_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid right after reset")

  `CLRS_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_seg_address) && $stable(out_seg_bytes) && $stable(out_status) && $stable(out_last), "stalled result changed")

  `CLRS_ASSERT(a_single_last, out_valid && out_status != clrs_pkg::ST_SEGMENT |-> out_last, "non-segment result without last")

  `CLRS_ASSERT(a_single_zero, out_valid && out_status != clrs_pkg::ST_SEGMENT |-> out_seg_address == '0 && out_seg_bytes == '0, "non-segment result carries address or size")

endmodule

bind cache_line_request_splitter_top clrs_checker u_clrs_checker (.*);

/* test/cache_line_request_splitter_checker.sv */
// checker that predicts the segments and credit answers of every accepted request and compares them
module cache_line_request_splitter_checker
  import clrs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_req_type,
  input  logic [KIND_W-1:0]        in_op_kind,
  input  logic [ADDR_W-1:0]        in_address,
  input  logic [BYTES_W-1:0]       in_byte_count,
  input  logic                     in_cacheable,
  input  logic                     in_atomic,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic [ADDR_W-1:0]        out_seg_address,
  input  logic [BYTES_W-1:0]       out_seg_bytes,
  input  logic [KIND_W-1:0]        out_seg_kind,
  input  logic                     out_last,
  output int                       errors,
  output int                       pending,
  output int                       checked,
  output logic [OP_KINDS*CNT_W-1:0] credits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t            status;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
    logic [KIND_W-1:0]  kind;
    logic               last;
  } seg_t;

  cfg_t                                shadow;
  logic [OP_KINDS-1:0][CNT_W-1:0]      in_use;
  seg_t                                owed[$];
  seg_t                                want;

  assign credits = in_use;

  task automatic split_request(input logic rt, input logic [KIND_W-1:0] k,
                               input logic [ADDR_W-1:0] a, input logic [BYTES_W-1:0] n,
                               input logic c, input logic at);
    seg_t        r;
    logic        cached;
    logic [ADDR_W-1:0] base;
    int unsigned lg, line, off, lines, lim, size, left;
    r.status = ST_SEGMENT;
    r.kind = k;
    r.addr = '0;
    r.bytes = '0;
    r.last = 1'b1;
    lg = shadow.line_log2;
    line = 1 << lg;
    off = a[15:0] & (line - 1);
    left = n;
    cached = shadow.cache_present && c;
    case (kind_t'(k))
      KIND_READ:                        lim = shadow.limit_read;
      KIND_WRITE:                       lim = shadow.limit_write;
      KIND_FLUSH:                       lim = shadow.limit_flush;
      KIND_READLOCK, KIND_WRITEUNLOCK:  lim = shadow.limit_lock_pair;
      KIND_LOADLINK, KIND_STORECOND:    lim = shadow.limit_link_pair;
      default:                          lim = shadow.limit_custom;
    endcase
    lines = (!cached || left == 0) ? 1 : ((off + left - 1) >> lg) + 1;
    if (rt) begin
      if (in_use[k] == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        in_use[k] = in_use[k] - 1'b1;
        r.status = ST_DONE_OK;
      end
      owed = {owed, r};
    end else if (lines > 1 && at) begin
      r.status = ST_ATOMIC_SPAN;
      owed = {owed, r};
    end else if (lines > lim || lines > DEF_MAX_SEGMENTS) begin
      r.status = ST_NEVER;
      owed = {owed, r};
    end else if (lines + in_use[k] > lim) begin
      r.status = ST_RETRY;
      owed = {owed, r};
    end else begin
      in_use[k] = in_use[k] + CNT_W'(lines);
      base = a;
      size = cached ? line - off : left;
      if (size > left) size = left;
      for (int i = 0; i < lines; i++) begin
        r.addr = base;
        r.bytes = BYTES_W'(size);
        r.last = (i == lines - 1);
        owed = {owed, r};
        base = base + size;
        left = left - size;
        size = left < line ? left : line;
      end
    end
  endtask

  function automatic void compare_field(input string name, input logic [ADDR_W-1:0] exp_v,
                                        input logic [ADDR_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow.cache_present = 1'b0;
      shadow.line_log2 = RST_LINE_LOG2;
      shadow.limit_read = RST_LIMIT;
      shadow.limit_write = RST_LIMIT;
      shadow.limit_flush = RST_LIMIT;
      shadow.limit_lock_pair = RST_LIMIT;
      shadow.limit_link_pair = RST_LIMIT;
      shadow.limit_custom = RST_LIMIT;
      in_use = '0;
      owed.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (owed.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, got status %0d addr %0h",
                   $time, out_status, out_seg_address);
          errors++;
        end else begin
          want = owed.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("seg_address", want.addr, out_seg_address);
          compare_field("seg_bytes", want.bytes, out_seg_bytes);
          compare_field("seg_kind", want.kind, out_seg_kind);
          compare_field("last", want.last, out_last);
        end
      end
      if (in_valid && !in_stall)
        split_request(in_req_type, in_op_kind, in_address, in_byte_count, in_cacheable,
                      in_atomic);
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CACHE_PRESENT:   shadow.cache_present = cfg_wdata[0];
          CFG_LINE_LOG2:       shadow.line_log2 = cfg_wdata[LG_W-1:0];
          CFG_LIMIT_READ:      shadow.limit_read = cfg_wdata;
          CFG_LIMIT_WRITE:     shadow.limit_write = cfg_wdata;
          CFG_LIMIT_FLUSH:     shadow.limit_flush = cfg_wdata;
          CFG_LIMIT_LOCK_PAIR: shadow.limit_lock_pair = cfg_wdata;
          CFG_LIMIT_LINK_PAIR: shadow.limit_link_pair = cfg_wdata;
          default:             shadow.limit_custom = cfg_wdata;
        endcase
      end
    end
    pending = owed.size();
  end

endmodule

/* test/testbench.sv */
// top of the splitter testbench: clock, reset, request stimulus, register settings and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import clrs_pkg::*;

  localparam int STUCK_LIMIT = 4000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_req_type = 1'b0;
  logic [KIND_W-1:0]         in_op_kind = '0;
  logic [ADDR_W-1:0]         in_address = '0;
  logic [BYTES_W-1:0]        in_byte_count = '0;
  logic                      in_cacheable = 1'b0;
  logic                      in_atomic = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic [ADDR_W-1:0]         out_seg_address;
  logic [BYTES_W-1:0]        out_seg_bytes;
  logic [KIND_W-1:0]         out_seg_kind;
  logic                      out_last;

  int                        errors;
  int                        pending;
  int                        checked;
  logic [OP_KINDS*CNT_W-1:0] credits;
  logic                      quiet = 1'b0;
  int                        sent = 0;
  int                        settings = 1;
  int unsigned               cur_lg = RST_LINE_LOG2;

  cache_line_request_splitter_top uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_req_type, .in_op_kind, .in_address, .in_byte_count,
    .in_cacheable, .in_atomic,
    .out_valid, .out_stall, .out_status, .out_seg_address, .out_seg_bytes, .out_seg_kind,
    .out_last
  );

  cache_line_request_splitter_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_req_type, .in_op_kind, .in_address, .in_byte_count,
    .in_cacheable, .in_atomic,
    .out_valid, .out_stall, .out_status, .out_seg_address, .out_seg_bytes, .out_seg_kind,
    .out_last,
    .errors, .pending, .checked, .credits
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) out_stall <= !quiet && ($urandom_range(99) < 15);

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("%0t: nothing moved for %0d cycles", $time, STUCK_LIMIT);
    $display("** cache_line_request_splitter_top: FAILED **");
    $finish;
  end

  task automatic send_req(input logic rt, input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                          input logic [BYTES_W-1:0] n, input logic c, input logic at);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_op_kind <= k;
    in_address <= a;
    in_byte_count <= n;
    in_cacheable <= c;
    in_atomic <= at;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic program_regs(input logic cache, input logic [LG_W-1:0] lg,
                              input logic [CNT_W-1:0] lr, lw, lf, lk, ln, lc);
    logic [CFG_W-1:0] vals [OP_KINDS];
    vals = '{CFG_W'(cache), CFG_W'(lg), lr, lw, lf, lk, ln, lc};
    for (int i = 0; i < OP_KINDS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_lg = lg;
    settings++;
  endtask

  task automatic random_request();
    logic [KIND_W-1:0] k;
    logic [ADDR_W-1:0] a;
    int unsigned       line, n, pick;
    line = 1 << cur_lg;
    k = KIND_W'($urandom_range(7));
    a = {$urandom, $urandom};
    if ($urandom_range(99) < 40) begin
      // completions mostly go to a kind that holds credits
      if ($urandom_range(99) < 85)
        for (int j = 0; j < OP_KINDS; j++)
          if (credits[CNT_W*k +: CNT_W] == 0) k = k + 1'b1;
      send_req(1'b1, k, a, BYTES_W'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      if ($urandom_range(99) < 10) a[63:16] = '1;
      pick = $urandom_range(99);
      if (pick < 5) n = 0;
      else if (pick < 55) n = $urandom_range(1, (2 * line > 4096) ? 4096 : 2 * line);
      else if (pick < 85) n = $urandom_range(1, 64);
      else n = $urandom_range(1, 4096);
      send_req(1'b0, k, a, BYTES_W'(n), $urandom_range(99) < 80, $urandom_range(99) < 15);
    end
  endtask

  task automatic run_phase(input logic cache, input logic [LG_W-1:0] lg,
                           input logic [CNT_W-1:0] lr, lw, lf, lk, ln, lc, input int items);
    drain();
    program_regs(cache, lg, lr, lw, lf, lk, ln, lc);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) drain();
      random_request();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: no cache, so nothing is split
    send_req(1'b0, KIND_READ, '1, 13'd4096, 1'b1, 1'b0);
    send_req(1'b1, KIND_READ, '0, '0, 1'b0, 1'b0);
    send_req(1'b1, KIND_READ, '0, '0, 1'b0, 1'b0);
    send_req(1'b0, KIND_CUSTOM, '0, '0, 1'b0, 1'b0);

    drain();
    program_regs(1'b1, 4'd6, 7'd64, 7'd1, 7'd0, 7'd2, 7'd3, 7'd64);
    send_req(1'b0, KIND_READ, 64'h0, 13'd4096, 1'b1, 1'b0);
    send_req(1'b0, KIND_READ, 64'h3f, 13'd4096, 1'b1, 1'b0);
    send_req(1'b0, KIND_READ, 64'h3c, 13'd8, 1'b1, 1'b0);
    send_req(1'b1, KIND_READ, '0, '0, 1'b0, 1'b0);
    send_req(1'b0, KIND_READ, 64'h40, 13'd8, 1'b1, 1'b1);
    send_req(1'b0, KIND_WRITE, 64'h3c, 13'd8, 1'b1, 1'b1);
    send_req(1'b0, KIND_WRITE, 64'h3c, 13'd8, 1'b1, 1'b0);
    send_req(1'b0, KIND_WRITE, 64'h10, 13'd8, 1'b1, 1'b0);
    send_req(1'b0, KIND_WRITE, 64'h10, 13'd8, 1'b1, 1'b0);
    send_req(1'b0, KIND_FLUSH, 64'h0, 13'd1, 1'b1, 1'b0);
    send_req(1'b0, KIND_READLOCK, 64'hffff_ffff_ffff_fff0, 13'd32, 1'b1, 1'b0);
    send_req(1'b0, KIND_WRITEUNLOCK, 64'h123, 13'd0, 1'b1, 1'b0);
    send_req(1'b0, KIND_LOADLINK, 64'h1000, 13'd200, 1'b0, 1'b0);
    send_req(1'b0, KIND_STORECOND, 64'h7, 13'd100, 1'b1, 1'b0);
    send_req(1'b0, KIND_STORECOND, 64'h40, 13'd64, 1'b1, 1'b0);
    send_req(1'b0, KIND_STORECOND, 64'h80, 13'd4, 1'b1, 1'b0);
    send_req(1'b1, KIND_FLUSH, '0, '0, 1'b0, 1'b0);
    send_req(1'b1, KIND_STORECOND, '0, '0, 1'b0, 1'b0);
    send_req(1'b1, KIND_WRITEUNLOCK, '0, '0, 1'b0, 1'b0);
    send_req(1'b1, KIND_CUSTOM, '0, '0, 1'b0, 1'b0);
    send_req(1'b0, KIND_CUSTOM, 64'h0, 13'd4096, 1'b1, 1'b0);

    run_phase(1'b1, 4'd6, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 25);
    run_phase(1'b1, 4'd2, 7'd4, 7'd0, 7'd64, 7'd1, 7'd32, 7'd16, 30);
    drain();
    quiet <= 1'b1;
    run_phase(1'b1, 4'd12, 7'd64, 7'd1, 7'd64, 7'd64, 7'd1, 7'd64, 30);
    drain();
    quiet <= 1'b0;
    run_phase(1'b0, 4'd6, 7'd10, 7'd64, 7'd0, 7'd64, 7'd20, 7'd3, 20);
    run_phase(1'b1, 4'd0, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 15);
    run_phase(1'b1, 4'd15, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 15);
    run_phase(1'b1, 4'd4, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 20);

    drain();
    repeat (20) @(negedge clk);
    $display("%0d requests sent under %0d register settings, %0d results checked",
             sent, settings, checked);
    $display("line sizes 1 byte to 32 KiB, limits 0 to 64, cache on and off, all kinds");
    if (errors == 0) begin
      $display("** cache_line_request_splitter_top: PASSED **");
    end else begin
      $display("** cache_line_request_splitter_top: FAILED **");
    end
    $finish;
  end

endmodule
